[hw/rtl/imptt_pkg.sv]
package imptt_pkg;

  // action codes carried on the request tuser
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_EDIT   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_EXEC   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  localparam int USER_W = 16;
  localparam int ID_W   = 10;
  localparam int PRI_W  = 32;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic              valid;
    logic [USER_W-1:0] user;
    logic [PRI_W-1:0]  pri;
  } slot_t;

  // control from the sequencer to the scan compare unit
  typedef struct packed {
    logic start;
    logic en;
  } scan_ctrl_t;

endpackage

[hw/rtl/imptt_scan.sv]
module imptt_scan #(
  parameter int IDX_W = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  imptt_pkg::scan_ctrl_t        ctrl,
  input  imptt_pkg::slot_t             entry,
  input  logic [IDX_W-1:0]             entry_addr,
  output logic                         found,
  output logic [IDX_W-1:0]             best_addr,
  output logic [imptt_pkg::USER_W-1:0] best_user
);
  import imptt_pkg::*;

  logic [PRI_W-1:0] best_pri;
  logic             take;

  // strictly greater wins; slots arrive from the highest id down,
  // so a tie keeps the higher id
  assign take = ctrl.en && entry.valid && (!found || (entry.pri > best_pri));

  always_ff @(posedge clk) begin
    if (rst || ctrl.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_pri  <= entry.pri;
      best_user <= entry.user;
      best_addr <= entry_addr;
    end
  end

endmodule

[hw/rtl/indexed_max_priority_task_table_unit.sv]
// Add, edit and remove: the slot is read, checked in S_LOOK and the result registered
// from S_FINISH; the next request is taken once the result is registered.
// Execute: the slot memory read port is stepped over all TASK_SLOTS slots, one per
// cycle, from the highest index down.
// Reset (rst, synchronous) starts a clearing pass over the valid marks of all
// TASK_SLOTS slots; no request is taken until it finishes.
module indexed_max_priority_task_table_unit #(
  parameter int TASK_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] user_id, [25:16] task_id, [57:26] priority_req, [63:58] zero
  input  logic [63:0] s_tdata,
  // [1:0] action
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] owner_out
  output logic [15:0] m_tdata,
  // [1:0] status
  output logic [1:0]  m_tuser
);
  import imptt_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CMP_W = 17;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_LOOK     = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_SCAN_END = 3'd4;
  localparam logic [2:0] S_EXEC_WR  = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  // latched request
  logic [1:0]        act_q;
  logic [USER_W-1:0] user_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PRI_W-1:0]  pri_q;
  logic              inr_q;

  // pending result
  logic [1:0]        res_status, res_status_next;
  logic [USER_W-1:0] res_owner, res_owner_next;

  // slot memory
  slot_t             mem [TASK_SLOTS];
  slot_t             rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  wa;
  slot_t             wd;

  // scan tag follows the registered read data
  logic              tag_valid;
  logic [IDX_W-1:0]  tag_addr;
  scan_ctrl_t        sc;
  logic              found;
  logic [IDX_W-1:0]  best_addr;
  logic [USER_W-1:0] best_user;

  logic              in_accept;
  logic [IDX_W-1:0]  in_idx;
  logic              in_range;
  logic [ID_W-1:0]   in_id;

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_id     = s_tdata[25:16];
  assign in_idx    = IDX_W'({{IDX_W{1'b0}}, in_id});
  assign in_range  = (CMP_W'(in_id) < CMP_W'(TASK_SLOTS));

  // read address: scan counter during execute, request id otherwise
  assign rd_addr = (state == S_SCAN) ? cnt : in_idx;

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // capture request fields
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_q  <= s_tuser;
      user_q <= s_tdata[15:0];
      idx_q  <= in_idx;
      pri_q  <= s_tdata[57:26];
      inr_q  <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    tag_addr <= cnt;
  end

  assign sc.start = in_accept;
  assign sc.en    = tag_valid;

  imptt_scan #(
    .IDX_W(IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sc),
    .entry     (rd_q),
    .entry_addr(tag_addr),
    .found     (found),
    .best_addr (best_addr),
    .best_user (best_user)
  );

  // sequencer
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_owner_next  = res_owner;
    we              = 1'b0;
    wa              = idx_q;
    wd              = '{valid: 1'b1, user: user_q, pri: pri_q};
    unique case (state)
      S_CLEAR: begin
        we       = 1'b1;
        wa       = cnt;
        wd.valid = 1'b0;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          cnt_next   = LAST_IDX;
          state_next = (s_tuser == ACT_EXEC) ? S_SCAN : S_LOOK;
        end
      end
      S_LOOK: begin
        res_owner_next = '0;
        state_next     = S_FINISH;
        priority if (!inr_q) begin
          res_status_next = STAT_NOT_FOUND;
        end else if (act_q == ACT_ADD) begin
          res_status_next = STAT_OK;
          we              = 1'b1;
        end else if (!rd_q.valid) begin
          res_status_next = STAT_NOT_FOUND;
        end else if (act_q == ACT_EDIT) begin
          res_status_next = STAT_OK;
          we              = 1'b1;
          wd.user         = rd_q.user;
        end else begin
          res_status_next = STAT_OK;
          we              = 1'b1;
          wd              = rd_q;
          wd.valid        = 1'b0;
        end
      end
      S_SCAN: begin
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_EXEC_WR;
      end
      S_EXEC_WR: begin
        state_next = S_FINISH;
        if (found) begin
          res_status_next = STAT_OK;
          res_owner_next  = best_user;
          we              = 1'b1;
          wa              = best_addr;
          wd.valid        = 1'b0;
        end else begin
          res_status_next = STAT_EMPTY;
          res_owner_next  = '0;
        end
      end
      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_owner  <= res_owner_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_FINISH) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && (!m_tvalid || m_tready)) begin
      m_tuser <= res_status;
      m_tdata <= res_owner;
    end
  end

endmodule

[test/indexed_max_priority_task_table_unit_tb.sv]
module indexed_max_priority_task_table_unit_tb;
  import imptt_pkg::*;

  localparam int TASK_SLOTS  = 1024;
  localparam int QUIET_LIMIT = 8000;  // clearing pass or one execute scan, plus stalls
  localparam int RAND_REQS   = 580;

  typedef struct packed {
    logic [1:0]        action;
    logic [USER_W-1:0] user;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
  } task_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [USER_W-1:0] owner;
  } task_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;  // [15:0] user_id, [25:16] task_id, [57:26] priority_req
  logic [1:0]  s_tuser = '0;  // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // [15:0] owner_out
  logic [1:0]  m_tuser;       // [1:0] status

  // task table shadow
  bit                tbl_valid [TASK_SLOTS];
  logic [USER_W-1:0] tbl_user  [TASK_SLOTS];
  logic [PRI_W-1:0]  tbl_pri   [TASK_SLOTS];

  task_req_t    pending_q[$];
  task_result_t result_q[$];
  int           total_reqs = 0;
  int           req_seen   = 0;
  int           err_count  = 0;
  int           quiet_cycles = 0;
  logic         req_fire = 1'b0;
  int           burst_left = 4;
  int           gap_left   = 0;
  logic [15:0]  stall_pat  = 16'hffff;
  int           stall_pos  = 0;

  indexed_max_priority_task_table_unit #(
    .TASK_SLOTS(TASK_SLOTS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // apply one request to the shadow table and return the expected result
  function automatic task_result_t table_apply(task_req_t r);
    task_result_t res;
    bit           found;
    int           top;
    logic [PRI_W-1:0] top_pri;
    res    = '0;
    found  = 1'b0;
    top    = 0;
    top_pri = '0;
    if (r.action == ACT_EXEC) begin
      // scan downwards, strictly greater wins so ties keep the higher id
      for (int k = TASK_SLOTS - 1; k >= 0; k--) begin
        if (tbl_valid[k] && (!found || tbl_pri[k] > top_pri)) begin
          found   = 1'b1;
          top     = k;
          top_pri = tbl_pri[k];
        end
      end
      if (found) begin
        res.status     = STAT_OK;
        res.owner      = tbl_user[top];
        tbl_valid[top] = 1'b0;
      end else begin
        res.status = STAT_EMPTY;
      end
    end else if (r.action == ACT_ADD) begin
      tbl_valid[r.id] = 1'b1;
      tbl_user[r.id]  = r.user;
      tbl_pri[r.id]   = r.pri;
      res.status      = STAT_OK;
    end else if (!tbl_valid[r.id]) begin
      res.status = STAT_NOT_FOUND;
    end else if (r.action == ACT_EDIT) begin
      tbl_pri[r.id] = r.pri;
      res.status    = STAT_OK;
    end else begin
      tbl_valid[r.id] = 1'b0;
      res.status      = STAT_OK;
    end
    return res;
  endfunction

  task automatic queue_req(logic [1:0] action, logic [USER_W-1:0] user,
                           logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
    task_req_t r;
    r.action = action;
    r.user   = user;
    r.id     = id;
    r.pri    = pri;
    pending_q.push_back(r);
    total_reqs++;
  endtask

  // request driver: bursts with random gaps, receiver stall pattern
  always @(negedge clk) begin
    logic      nxt_valid;
    task_req_t nxt;
    nxt_valid = s_tvalid;
    if (!rst && (!s_tvalid || req_fire)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        nxt = pending_q.pop_front();
        s_tdata <= {6'd0, nxt.pri, nxt.id, nxt.user};
        s_tuser <= nxt.action;
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          if ($urandom_range(0, 3) == 0)
            gap_left = 0;
          else if ($urandom_range(0, 7) == 0)
            gap_left = $urandom_range(10, 40);
          else
            gap_left = $urandom_range(1, 6);
        end
      end
    end
    s_tvalid <= nxt_valid;

    m_tready <= stall_pat[stall_pos];
    if (stall_pos == 15) begin
      stall_pos = 0;
      case ($urandom_range(0, 3))
        0: stall_pat = 16'hffff;
        1: stall_pat = 16'($urandom);
        2: stall_pat = 16'($urandom | $urandom);
        default: stall_pat = 16'($urandom & $urandom);
      endcase
    end else begin
      stall_pos++;
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    task_req_t    r;
    task_result_t want;
    req_fire <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      r.action = s_tuser;
      r.user   = s_tdata[15:0];
      r.id     = s_tdata[25:16];
      r.pri    = s_tdata[57:26];
      result_q.push_back(table_apply(r));
      req_seen++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: status %0d owner_out %0h", m_tuser, m_tdata);
        err_count++;
      end else begin
        want = result_q.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          err_count++;
        end
        if (m_tdata !== want.owner) begin
          $error("owner_out: expected %0h, got %0h", want.owner, m_tdata);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("indexed_max_priority_task_table_unit test failed");
      $finish;
    end
  end

  initial begin
    int               pool_base;
    logic [1:0]       act;
    logic [USER_W-1:0] user;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    int               pick;

    // directed: empty table, absent ids, extremes, overwrite, ties
    queue_req(ACT_EXEC,   16'h0000, 10'd0,    32'h0);
    queue_req(ACT_EDIT,   16'h1111, 10'd5,    32'h5);
    queue_req(ACT_REMOVE, 16'h2222, 10'd1023, 32'h0);
    queue_req(ACT_ADD,    16'h0000, 10'd0,    32'h0000_0000);
    queue_req(ACT_ADD,    16'hffff, 10'd1023, 32'hffff_ffff);
    queue_req(ACT_ADD,    16'h1234, 10'd512,  32'h0000_0000);
    queue_req(ACT_ADD,    16'habcd, 10'd512,  32'h7fff_ffff);
    queue_req(ACT_EDIT,   16'h0000, 10'd0,    32'h8000_0000);
    queue_req(ACT_EXEC,   16'hffff, 10'd1023, 32'hffff_ffff);
    queue_req(ACT_EXEC,   16'h0000, 10'd0,    32'h0);
    queue_req(ACT_REMOVE, 16'h0000, 10'd512,  32'h0);
    queue_req(ACT_REMOVE, 16'h0000, 10'd512,  32'h0);
    queue_req(ACT_EDIT,   16'h0000, 10'd512,  32'h1);
    queue_req(ACT_EXEC,   16'h0000, 10'd0,    32'h0);
    queue_req(ACT_ADD,    16'h0003, 10'd3,    32'h5);
    queue_req(ACT_ADD,    16'h0384, 10'd900,  32'h5);
    queue_req(ACT_ADD,    16'h000a, 10'd10,   32'h5);
    queue_req(ACT_EDIT,   16'h0000, 10'd3,    32'hffff_ffff);
    queue_req(ACT_EXEC,   16'h0000, 10'd0,    32'h0);
    queue_req(ACT_EXEC,   16'h0000, 10'd0,    32'h0);
    queue_req(ACT_EXEC,   16'h0000, 10'd0,    32'h0);
    queue_req(ACT_EXEC,   16'h0000, 10'd0,    32'h0);

    // random: ids mostly from a shifting pool so edits and removes hit live tasks
    pool_base = 0;
    for (int n = 0; n < RAND_REQS; n++) begin
      if (n % 64 == 0)
        pool_base = $urandom_range(0, TASK_SLOTS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 37)      act = ACT_ADD;
      else if (pick < 57) act = ACT_EDIT;
      else if (pick < 75) act = ACT_REMOVE;
      else                act = ACT_EXEC;

      pick = $urandom_range(0, 9);
      if (pick < 7)       id = ID_W'(pool_base + $urandom_range(0, 31));
      else if (pick == 7) id = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
      else                id = ID_W'($urandom_range(0, TASK_SLOTS - 1));

      pick = $urandom_range(0, 19);
      if (pick < 8)       pri = $urandom_range(0, 7);
      else if (pick < 14) pri = $urandom;
      else if (pick < 17) pri = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hffff_ffff;
      else                pri = 32'hffff_ffff - $urandom_range(0, 7);

      pick = $urandom_range(0, 9);
      if (pick == 0)      user = 16'h0000;
      else if (pick == 1) user = 16'hffff;
      else                user = USER_W'($urandom_range(0, 65535));

      queue_req(act, user, id, pri);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_seen < total_reqs || result_q.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_count == 0)
      $display("indexed_max_priority_task_table_unit test passed");
    else
      $display("indexed_max_priority_task_table_unit test failed");
    $finish;
  end

endmodule
